### rtl/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

   // sine and cosine magnitudes in Q30, with one spare bit so that 1.0 fits
   localparam int SINE_FRAC = 30;
   localparam int SINE_W    = 31;
   localparam int TRIG_W    = 32;
   localparam int HORNER_STEPS = 6;

   localparam logic [SINE_W-1:0] SINE_ONE  = 31'h4000_0000;
   localparam logic [SINE_W-1:0] SINE_HALF = 31'h2000_0000;

   localparam logic [SINE_W-1:0] SINE_COEF_TOP = 31'd61;
   localparam logic [SINE_W-1:0] SINE_COEF [0:HORNER_STEPS-1] = '{
      31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
   };

   // pipeline registers from u_in to s_out of the quarter sine pipeline
   localparam int SINE_LAT = HORNER_STEPS + 2;

   typedef enum logic [1:0] {
      QUAD_I,
      QUAD_II,
      QUAD_III,
      QUAD_IV
   } quadrant_type;

endpackage

### rtl/prc_quarter_sine.sv
`timescale 1ns / 1ps

module prc_quarter_sine
   import prc_pkg::*;
(
   input  logic              clock,
   input  logic [SINE_W-1:0] u_in,
   output logic [SINE_W-1:0] s_out
);

   logic [SINE_FRAC-1:0] u_ff    [0:HORNER_STEPS];
   logic                 full_ff [0:HORNER_STEPS];
   logic [SINE_W-1:0]    q_ff    [0:HORNER_STEPS-1];
   logic [SINE_W-1:0]    p_ff    [0:HORNER_STEPS-1];
   logic [SINE_W-1:0]    p_in    [0:HORNER_STEPS-1];

   logic [60:0] sq_sum;
   logic [SINE_W-1:0] q_in;
   logic [61:0] r_sum;
   logic [31:0] r_val;
   logic [SINE_W-1:0] s_in;
   logic [SINE_W-1:0] s_ff;

   // square of the argument
   always_comb begin
      sq_sum = 61'(u_in[SINE_FRAC-1:0]) * 61'(u_in[SINE_FRAC-1:0]) + 61'(SINE_HALF);
      q_in   = sq_sum[60:SINE_FRAC];
   end

   always_ff @(posedge clock) begin
      u_ff[0]    <= u_in[SINE_FRAC-1:0];
      full_ff[0] <= u_in[SINE_FRAC];
      q_ff[0]    <= q_in;
   end

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
      logic [SINE_W-1:0] p_prev;
      logic [62:0]       pq_sum;
      logic [32:0]       pq_shift;

      assign p_prev = (k == 0) ? SINE_COEF_TOP : p_ff[(k == 0) ? 0 : k - 1];

      always_comb begin
         pq_sum   = 63'(p_prev) * 63'(q_ff[k]) + 63'(SINE_HALF);
         pq_shift = pq_sum[62:SINE_FRAC];
         p_in[k]  = SINE_W'(33'(SINE_COEF[k]) - pq_shift);
      end

      always_ff @(posedge clock) begin
         p_ff[k]      <= p_in[k];
         u_ff[k+1]    <= u_ff[k];
         full_ff[k+1] <= full_ff[k];
      end

      if (k < HORNER_STEPS - 1) begin : g_q
         always_ff @(posedge clock) begin
            q_ff[k+1] <= q_ff[k];
         end
      end
   end

   // final multiply by the argument, clamp to one
   always_comb begin
      r_sum = 62'(p_ff[HORNER_STEPS-1]) * 62'(u_ff[HORNER_STEPS]) + 62'(SINE_HALF);
      r_val = r_sum[61:SINE_FRAC];
      if (full_ff[HORNER_STEPS] || (r_val > 32'(SINE_ONE))) begin
         s_in = SINE_ONE;
      end else begin
         s_in = r_val[SINE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
   end

   assign s_out = s_ff;

endmodule

### rtl/prc_split_mult.sv
`timescale 1ns / 1ps

module prc_split_mult
   import prc_pkg::*;
#(
   parameter int A_BITS = 33
)
(
   input  logic                             clock,
   input  logic signed [A_BITS-1:0]         a_in,
   input  logic signed [TRIG_W-1:0]         b_in,
   output logic signed [A_BITS+TRIG_W-1:0]  p_out
);

   localparam int LO_BITS = A_BITS / 2;
   localparam int HI_BITS = A_BITS - LO_BITS;
   localparam int PW      = A_BITS + TRIG_W;

   logic signed [LO_BITS:0]          a_lo;
   logic signed [HI_BITS-1:0]        a_hi;
   logic signed [LO_BITS+TRIG_W:0]   pp_lo_in, pp_lo_ff;
   logic signed [HI_BITS+TRIG_W-1:0] pp_hi_in, pp_hi_ff;
   logic signed [PW-1:0]             hi_ext, lo_ext, p_in, p_ff;

   // low half as a non-negative operand, high half keeps the sign
   assign a_lo     = {1'b0, a_in[LO_BITS-1:0]};
   assign a_hi     = a_in[A_BITS-1:LO_BITS];
   assign pp_lo_in = a_lo * b_in;
   assign pp_hi_in = a_hi * b_in;

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
   end

   assign hi_ext = {pp_hi_ff, {LO_BITS{1'b0}}};
   assign lo_ext = PW'(pp_lo_ff);
   assign p_in   = hi_ext + lo_ext;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p_out = p_ff;

endmodule

### rtl/point_rotate_about_center_unit.sv
`timescale 1ns / 1ps
// channel   ports                                         handshake
// request   req_point_x/y, req_center_x/y, req_turn_angle  start, busy
// response  rsp_rotated_x/y, rsp_saturated                 rsp_valid (one-cycle strobe)
//
// One word is accepted in every cycle; busy is always low.
// A word accepted at one edge shows on the response ports for one cycle, after the input
// register, the quarter sine pipeline (squaring, six Horner steps, final multiply), the
// split multipliers' partial product and sum registers, the row and output registers.
// Reset clears the valid chain only; the receiver cannot stall the pipeline.

module point_rotate_about_center_unit
   import prc_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int ANGLE_BITS = 16
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,
   input  logic signed [COORD_BITS-1:0] req_center_x,
   input  logic signed [COORD_BITS-1:0] req_center_y,
   input  logic        [ANGLE_BITS-1:0] req_turn_angle,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_rotated_x,
   output logic signed [COORD_BITS-1:0] rsp_rotated_y,
   output logic                         rsp_saturated
);

   localparam int QB      = ANGLE_BITS - 2;
   localparam int D       = COORD_BITS + 1;
   localparam int PW      = D + TRIG_W;
   localparam int RW      = PW + 1;
   localparam int SW      = COORD_BITS + 5;
   localparam int MUL_LAT = 2;
   localparam int TRIG_AT = SINE_LAT;
   localparam int ROW_AT  = TRIG_AT + MUL_LAT + 1;
   localparam int OUT_AT  = ROW_AT + 1;

   localparam logic signed [RW-1:0] ROUND_HALF = {{(RW-SINE_FRAC){1'b0}}, 1'b1,
                                                 {(SINE_FRAC-1){1'b0}}};
   localparam logic signed [SW-1:0] COORD_MAX = {{(SW-COORD_BITS+1){1'b0}},
                                                {(COORD_BITS-1){1'b1}}};
   localparam logic signed [SW-1:0] COORD_MIN = {{(SW-COORD_BITS+1){1'b1}},
                                                {(COORD_BITS-1){1'b0}}};

   logic [OUT_AT:0] vld_ff;

   logic signed [D-1:0]          dx_ff   [0:TRIG_AT];
   logic signed [D-1:0]          dy_ff   [0:TRIG_AT];
   quadrant_type                 quad_ff [0:TRIG_AT];
   logic signed [COORD_BITS-1:0] cx_ff   [0:ROW_AT];
   logic signed [COORD_BITS-1:0] cy_ff   [0:ROW_AT];
   logic [QB-1:0]                t_ff;

   logic [SINE_W-1:0] u_t, u_c, s_t, s_c;
   logic signed [TRIG_W-1:0] sn, cs;
   logic signed [PW-1:0] dx_cs, dy_sn, dx_sn, dy_cs;
   logic signed [RW-1:0] row_x_in, row_y_in, row_x_ff, row_y_ff;
   logic signed [SW-1:0] sum_x, sum_y;
   logic [COORD_BITS:0] clamp_x, clamp_y;

   assign busy = 1'b0;

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[OUT_AT-1:0], start & ~busy};
      end
   end

   // input register: offsets from the center and the split angle
   always_ff @(posedge clock) begin
      dx_ff[0]   <= D'(req_point_x) - D'(req_center_x);
      dy_ff[0]   <= D'(req_point_y) - D'(req_center_y);
      cx_ff[0]   <= req_center_x;
      cy_ff[0]   <= req_center_y;
      quad_ff[0] <= quadrant_type'(req_turn_angle[ANGLE_BITS-1:QB]);
      t_ff       <= req_turn_angle[QB-1:0];
   end

   // hold offsets and quadrant while the sine pipeline runs
   for (genvar k = 1; k <= TRIG_AT; k++) begin : g_trig_delay
      always_ff @(posedge clock) begin
         dx_ff[k]   <= dx_ff[k-1];
         dy_ff[k]   <= dy_ff[k-1];
         quad_ff[k] <= quad_ff[k-1];
      end
   end

   for (genvar k = 1; k <= ROW_AT; k++) begin : g_center_delay
      always_ff @(posedge clock) begin
         cx_ff[k] <= cx_ff[k-1];
         cy_ff[k] <= cy_ff[k-1];
      end
   end

   assign u_t = {1'b0, t_ff, {(SINE_FRAC-QB){1'b0}}};
   assign u_c = SINE_ONE - u_t;

   prc_quarter_sine u_sine_t (
      .clock (clock),
      .u_in  (u_t),
      .s_out (s_t)
   );

   prc_quarter_sine u_sine_c (
      .clock (clock),
      .u_in  (u_c),
      .s_out (s_c)
   );

   always_comb begin
      case (quad_ff[TRIG_AT])
         QUAD_I: begin
            sn = TRIG_W'(s_t);
            cs = TRIG_W'(s_c);
         end
         QUAD_II: begin
            sn = TRIG_W'(s_c);
            cs = -TRIG_W'(s_t);
         end
         QUAD_III: begin
            sn = -TRIG_W'(s_t);
            cs = -TRIG_W'(s_c);
         end
         default: begin
            sn = -TRIG_W'(s_c);
            cs = TRIG_W'(s_t);
         end
      endcase
   end

   prc_split_mult #(.A_BITS(D)) u_mul_dx_cs (
      .clock (clock), .a_in (dx_ff[TRIG_AT]), .b_in (cs), .p_out (dx_cs)
   );

   prc_split_mult #(.A_BITS(D)) u_mul_dy_sn (
      .clock (clock), .a_in (dy_ff[TRIG_AT]), .b_in (sn), .p_out (dy_sn)
   );

   prc_split_mult #(.A_BITS(D)) u_mul_dx_sn (
      .clock (clock), .a_in (dx_ff[TRIG_AT]), .b_in (sn), .p_out (dx_sn)
   );

   prc_split_mult #(.A_BITS(D)) u_mul_dy_cs (
      .clock (clock), .a_in (dy_ff[TRIG_AT]), .b_in (cs), .p_out (dy_cs)
   );

   // matrix rows with the rounding offset folded in
   assign row_x_in = RW'(dx_cs) - RW'(dy_sn) + ROUND_HALF;
   assign row_y_in = RW'(dx_sn) + RW'(dy_cs) + ROUND_HALF;

   always_ff @(posedge clock) begin
      row_x_ff <= row_x_in;
      row_y_ff <= row_y_in;
   end

   function automatic logic [COORD_BITS:0] clamp_coord(input logic signed [SW-1:0] v);
      logic [COORD_BITS:0] res;
      if (v > COORD_MAX) begin
         res = {1'b1, COORD_MAX[COORD_BITS-1:0]};
      end else if (v < COORD_MIN) begin
         res = {1'b1, COORD_MIN[COORD_BITS-1:0]};
      end else begin
         res = {1'b0, v[COORD_BITS-1:0]};
      end
      return res;
   endfunction

   // drop the fraction bits, add the center back, clamp
   assign sum_x = SW'(cx_ff[ROW_AT]) + SW'($signed(row_x_ff[RW-1:SINE_FRAC]));
   assign sum_y = SW'(cy_ff[ROW_AT]) + SW'($signed(row_y_ff[RW-1:SINE_FRAC]));
   assign clamp_x = clamp_coord(sum_x);
   assign clamp_y = clamp_coord(sum_y);

   always_ff @(posedge clock) begin
      rsp_rotated_x <= clamp_x[COORD_BITS-1:0];
      rsp_rotated_y <= clamp_y[COORD_BITS-1:0];
      rsp_saturated <= clamp_x[COORD_BITS] | clamp_y[COORD_BITS];
   end

   assign rsp_valid = vld_ff[OUT_AT];

endmodule
